FILE: rtl/twd_enc_pkg.sv
// ----------------------------------------------------------------------------
// twd_enc_pkg: shared types and constants for the drive command encoder
// Command and frame words, register indexes, frame codes and fixed-point
// constants for three-wheel omni inverse kinematics.
// ----------------------------------------------------------------------------
package twd_enc_pkg;

   // speed field width of the motor frame
   localparam int SPEED_BITS = 12;
   localparam int SPEED_FULL = (1 << SPEED_BITS) - 1;
   localparam logic [11:0] SPEED_CAP = (SPEED_FULL > 4095) ? 12'd4095 : 12'(SPEED_FULL);

   // register indexes
   localparam logic [1:0] CSR_ACCEL  = 2'd0;
   localparam logic [1:0] CSR_LIMIT  = 2'd1;
   localparam logic [1:0] CSR_OFFSET = 2'd2;
   localparam logic [1:0] CSR_GAIN   = 2'd3;

   // register reset values
   localparam logic [7:0]  ACCEL_RESET  = 8'd2;
   localparam logic [11:0] LIMIT_RESET  = 12'd3000;
   localparam logic [9:0]  OFFSET_RESET = 10'd150;
   localparam logic [15:0] GAIN_RESET   = 16'd20861;

   // command codes on the input word
   localparam logic CMD_VELOCITY = 1'b0;
   localparam logic CMD_ENABLE   = 1'b1;

   // frame codes
   localparam logic [7:0] CODE_SPEED  = 8'hF6;
   localparam logic [7:0] CODE_ENABLE = 8'hF3;
   localparam logic [7:0] ENABLE_ARG  = 8'h01;
   localparam logic [2:0] FRAME_LEN_SPEED  = 3'd5;
   localparam logic [2:0] FRAME_LEN_ENABLE = 3'd3;

   // wheel slots
   localparam logic [1:0] WHEEL_A = 2'd0;
   localparam logic [1:0] WHEEL_B = 2'd1;
   localparam logic [1:0] WHEEL_C = 2'd2;

   // sin(60 deg) in Q16
   localparam logic signed [16:0] SIN60_Q16 = 17'sd56756;
   // reciprocal of 125, exact floor for dividends below 2^26 (shift 33)
   localparam logic [26:0] RECIP125_WIDE = 27'd68719477;
   // reciprocal of 125, exact floor for dividends below 2^14 (shift 21)
   localparam logic [14:0] RECIP125_NARROW = 15'd16778;

   typedef struct packed {
      logic               cmd;
      logic signed [15:0] vel_x;
      logic signed [15:0] vel_y;
      logic signed [15:0] turn_rate;
   } req_word_type;

   typedef struct packed {
      logic [1:0] motor_id;
      logic [2:0] frame_length;
      logic [7:0] code_byte;
      logic [7:0] second_byte;
      logic [7:0] third_byte;
      logic [7:0] fourth_byte;
      logic [7:0] fifth_byte;
      logic       last_frame;
   } rsp_word_type;

   // control that rides along with every wheel slot
   typedef struct packed {
      logic       cmd;
      logic [1:0] wheel;
   } slot_ctl_type;

endpackage

FILE: rtl/three_wheel_drive_command_encoder_top.sv
// ----------------------------------------------------------------------------
// three_wheel_drive_command_encoder_top: omni drive command to motor frames
// One command word becomes three motor frames (wheels 1, 2, 3). Velocity
// commands go through fixed-point inverse kinematics, rpm scaling and
// saturation; enable commands give three fixed enable frames.
//
//   channel  ports                        direction  handshake
//   req      req_valid req_stall req_word  in         valid / stall
//   rsp      rsp_valid rsp_stall rsp_word  out        valid / stall
//   csr      csr_wr_en csr_index csr_wr_data in       write enable only
//
// The issue stage sends one wheel slot per cycle into an 8-stage pipeline,
// unless a stall on rsp holds it; a new command is taken as the last slot of
// the previous one leaves. Synchronous active-high reset clears the valid
// bits and loads the configuration registers with their reset values.
// A stall on rsp freezes the whole pipeline; a command can still be taken
// into the issue stage while it is empty.
// ----------------------------------------------------------------------------
module three_wheel_drive_command_encoder_top
   import twd_enc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wr_data
);

   // ---------------------------------------------------------------- config
   logic [7:0]  accel_ff, accel_in;
   logic [11:0] limit_ff, limit_in;
   logic [9:0]  offset_ff, offset_in;
   logic [15:0] gain_ff, gain_in;

   assign accel_in  = (csr_wr_en && csr_index == CSR_ACCEL)  ? csr_wr_data[7:0]  : accel_ff;
   assign limit_in  = (csr_wr_en && csr_index == CSR_LIMIT)  ? csr_wr_data[11:0] : limit_ff;
   assign offset_in = (csr_wr_en && csr_index == CSR_OFFSET) ? csr_wr_data[9:0]  : offset_ff;
   assign gain_in   = (csr_wr_en && csr_index == CSR_GAIN)   ? csr_wr_data      : gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff  <= ACCEL_RESET;
         limit_ff  <= LIMIT_RESET;
         offset_ff <= OFFSET_RESET;
         gain_ff   <= GAIN_RESET;
      end else begin
         accel_ff  <= accel_in;
         limit_ff  <= limit_in;
         offset_ff <= offset_in;
         gain_ff   <= gain_in;
      end
   end

   // pipeline moves unless the output word is held by a stall
   logic adv;
   logic rsp_valid_ff, rsp_valid_in;
   assign adv = !rsp_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------- issue
   logic         hold_valid_ff, hold_valid_in;
   req_word_type hold_word_ff, hold_word_in;
   logic [1:0]   wheel_ff, wheel_in;
   logic         req_take;

   assign req_stall = hold_valid_ff && !(adv && wheel_ff == WHEEL_C);
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_word_in  = hold_word_ff;
      wheel_in      = wheel_ff;
      if (hold_valid_ff && adv) begin
         if (wheel_ff == WHEEL_C) begin
            hold_valid_in = 1'b0;
         end else begin
            wheel_in = wheel_ff + 2'd1;
         end
      end
      if (req_take) begin
         hold_valid_in = 1'b1;
         hold_word_in  = req_word;
         wheel_in      = WHEEL_A;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         wheel_ff      <= WHEEL_A;
      end else begin
         hold_valid_ff <= hold_valid_in;
         wheel_ff      <= wheel_in;
      end
      hold_word_ff <= hold_word_in;
   end

   // ---------------------------------------------------------------- stage 1
   // offset * turn rate magnitude, vy * sin60
   logic               s1_valid_ff;
   slot_ctl_type       s1_ctl_ff, s1_ctl_in;
   logic signed [15:0] s1_vx_ff, s1_vx_in;
   logic signed [32:0] s1_vyk_ff, s1_vyk_in;
   logic [25:0]        s1_m_ff, s1_m_in;
   logic               s1_tneg_ff, s1_tneg_in;
   logic signed [26:0] off_wz;

   always_comb begin
      off_wz        = $signed({1'b0, offset_ff}) * hold_word_ff.turn_rate;
      s1_ctl_in     = '{cmd: hold_word_ff.cmd, wheel: wheel_ff};
      s1_vx_in      = hold_word_ff.vel_x;
      s1_vyk_in     = hold_word_ff.vel_y * SIN60_Q16;
      s1_tneg_in    = off_wz[26];
      s1_m_in       = off_wz[26] ? 26'(-off_wz) : off_wz[25:0];
   end

   // ---------------------------------------------------------------- stage 2
   // m / 125 by reciprocal, per-wheel base term
   logic         s2_valid_ff;
   slot_ctl_type s2_ctl_ff;
   logic [25:0]  s2_m_ff;
   logic [18:0]  s2_a_ff, s2_a_in;
   logic         s2_tneg_ff;
   logic [33:0]  s2_base_ff, s2_base_in;
   logic [52:0]  a_prod;
   logic [33:0]  vx_q16, vx_q15, vyk_ext;

   always_comb begin
      a_prod  = s1_m_ff * RECIP125_WIDE;
      s2_a_in = a_prod[51:33];
      vx_q16  = {{2{s1_vx_ff[15]}}, s1_vx_ff, 16'd0};
      vx_q15  = {{3{s1_vx_ff[15]}}, s1_vx_ff, 15'd0};
      vyk_ext = {s1_vyk_ff[32], s1_vyk_ff};
      unique case (s1_ctl_ff.wheel)
         WHEEL_B: s2_base_in = vyk_ext - vx_q15;
         WHEEL_C: s2_base_in = -vx_q15 - vyk_ext;
         default: s2_base_in = vx_q16;
      endcase
   end

   // ---------------------------------------------------------------- stage 3
   // remainder term 67*b and 65*m + 67*a
   logic         s3_valid_ff;
   slot_ctl_type s3_ctl_ff;
   logic [13:0]  s3_r_ff, s3_r_in;
   logic [31:0]  s3_sum_ff, s3_sum_in;
   logic         s3_tneg_ff;
   logic [33:0]  s3_base_ff;
   logic [25:0]  b_full;

   always_comb begin
      b_full    = s2_m_ff - ({7'd0, s2_a_ff} * 26'd125);
      s3_r_in   = {7'd0, b_full[6:0]} * 14'd67;
      s3_sum_in = ({6'd0, s2_m_ff} * 32'd65) + ({13'd0, s2_a_ff} * 32'd67);
   end

   // ---------------------------------------------------------------- stage 4
   // |T| = 65m + 67a + floor(67b / 125)
   logic         s4_valid_ff;
   slot_ctl_type s4_ctl_ff;
   logic [31:0]  s4_tmag_ff, s4_tmag_in;
   logic         s4_tneg_ff;
   logic [33:0]  s4_base_ff;
   logic [28:0]  c_prod;

   always_comb begin
      c_prod     = {15'd0, s3_r_ff} * 29'(RECIP125_NARROW);
      s4_tmag_in = s3_sum_ff + {24'd0, c_prod[28:21]};
   end

   // ---------------------------------------------------------------- stage 5
   // wheel speed S in signed Q16 mm/s
   logic         s5_valid_ff;
   slot_ctl_type s5_ctl_ff;
   logic [33:0]  s5_s_ff, s5_s_in;
   logic [33:0]  t_signed;

   always_comb begin
      t_signed = s4_tneg_ff ? -{2'b00, s4_tmag_ff} : {2'b00, s4_tmag_ff};
      s5_s_in  = s4_base_ff + t_signed;
   end

   // ---------------------------------------------------------------- stage 6
   // sign and magnitude of S
   logic         s6_valid_ff;
   slot_ctl_type s6_ctl_ff;
   logic [32:0]  s6_sabs_ff, s6_sabs_in;
   logic         s6_sneg_ff, s6_sneg_in;

   assign s6_sneg_in = s5_s_ff[33];
   assign s6_sabs_in = s5_s_ff[33] ? 33'(-s5_s_ff) : s5_s_ff[32:0];

   // ---------------------------------------------------------------- stage 7
   // |S| * gain, Q32 rpm
   logic         s7_valid_ff;
   slot_ctl_type s7_ctl_ff;
   logic [48:0]  s7_prod_ff, s7_prod_in;
   logic         s7_sneg_ff;

   assign s7_prod_in = {16'd0, s6_sabs_ff} * {33'd0, gain_ff};

   // ---------------------------------------------------------------- stage 8
   // saturate and pack the frame word
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic [16:0]  spd_raw;
   logic [11:0]  spd_lim, spd;
   logic         dir;
   logic [7:0]   b2, b3;

   always_comb begin
      spd_raw = s7_prod_ff[48:32];
      spd_lim = (limit_ff > SPEED_CAP) ? SPEED_CAP : limit_ff;
      spd     = (spd_raw > {5'd0, spd_lim}) ? spd_lim : spd_raw[11:0];
      dir     = !s7_sneg_ff || (gain_ff == 16'd0);
      b2      = {dir, 3'b000, spd[11:8]};
      b3      = spd[7:0];
      rsp_word_in.motor_id   = s7_ctl_ff.wheel + 2'd1;
      rsp_word_in.last_frame = (s7_ctl_ff.wheel == WHEEL_C);
      if (s7_ctl_ff.cmd == CMD_ENABLE) begin
         rsp_word_in.frame_length = FRAME_LEN_ENABLE;
         rsp_word_in.code_byte    = CODE_ENABLE;
         rsp_word_in.second_byte  = ENABLE_ARG;
         rsp_word_in.third_byte   = CODE_ENABLE ^ ENABLE_ARG;
         rsp_word_in.fourth_byte  = 8'd0;
         rsp_word_in.fifth_byte   = 8'd0;
      end else begin
         rsp_word_in.frame_length = FRAME_LEN_SPEED;
         rsp_word_in.code_byte    = CODE_SPEED;
         rsp_word_in.second_byte  = b2;
         rsp_word_in.third_byte   = b3;
         rsp_word_in.fourth_byte  = accel_ff;
         rsp_word_in.fifth_byte   = CODE_SPEED ^ b2 ^ b3 ^ accel_ff;
      end
   end

   assign rsp_valid_in = s7_valid_ff;

   // ---------------------------------------------------------------- registers
   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= hold_valid_ff;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         s7_valid_ff  <= s6_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ctl_ff   <= s1_ctl_in;
         s1_vx_ff    <= s1_vx_in;
         s1_vyk_ff   <= s1_vyk_in;
         s1_m_ff     <= s1_m_in;
         s1_tneg_ff  <= s1_tneg_in;

         s2_ctl_ff   <= s1_ctl_ff;
         s2_m_ff     <= s1_m_ff;
         s2_a_ff     <= s2_a_in;
         s2_tneg_ff  <= s1_tneg_ff;
         s2_base_ff  <= s2_base_in;

         s3_ctl_ff   <= s2_ctl_ff;
         s3_r_ff     <= s3_r_in;
         s3_sum_ff   <= s3_sum_in;
         s3_tneg_ff  <= s2_tneg_ff;
         s3_base_ff  <= s2_base_ff;

         s4_ctl_ff   <= s3_ctl_ff;
         s4_tmag_ff  <= s4_tmag_in;
         s4_tneg_ff  <= s3_tneg_ff;
         s4_base_ff  <= s3_base_ff;

         s5_ctl_ff   <= s4_ctl_ff;
         s5_s_ff     <= s5_s_in;

         s6_ctl_ff   <= s5_ctl_ff;
         s6_sabs_ff  <= s6_sabs_in;
         s6_sneg_ff  <= s6_sneg_in;

         s7_ctl_ff   <= s6_ctl_ff;
         s7_prod_ff  <= s7_prod_in;
         s7_sneg_ff  <= s6_sneg_ff;

         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // ---------------------------------------------------------------- checks
   // third wheel and only it closes the run
   a_last_is_third: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_word_ff.last_frame == (rsp_word_ff.motor_id == 2'd3)))
      else $error("last_frame does not match motor 3");

   // frame length follows the code byte
   a_len_matches_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_word_ff.code_byte == CODE_ENABLE)
                        == (rsp_word_ff.frame_length == FRAME_LEN_ENABLE)))
      else $error("frame length does not match code byte");

   // speed never above the programmed limit
   a_speed_limited: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.frame_length == FRAME_LEN_SPEED)
      |-> ({rsp_word_ff.second_byte[3:0], rsp_word_ff.third_byte} <= limit_ff))
      else $error("speed above limit");

   // reset empties the issue stage and the output word
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !hold_valid_ff))
      else $error("pipeline not empty after reset");

endmodule
